@@ hw/rtl/sparse_row_product_top_n_defines.svh @@
// Assertion macros used by the sparse row product RTL.
`ifndef SPARSE_ROW_PRODUCT_TOP_N_DEFINES_SVH
`define SPARSE_ROW_PRODUCT_TOP_N_DEFINES_SVH
`ifndef SYNTHESIS
`define SRP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRP_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRP_ASSERT(label, clk, rst_n, prop, msg)
`define SRP_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ hw/rtl/srp_pkg.sv @@
// ----------------------------------------------------------------------------
// srp_pkg
// Types, constants and helpers for the sparse row product block.
// ----------------------------------------------------------------------------
package srp_pkg;

    localparam int NUM_COLUMNS = 1024;
    localparam int B_ROWS      = 1024;
    localparam int B_ENTRIES   = 4096;
    localparam int TOP_MAX     = 64;

    localparam int COL_W  = $clog2(NUM_COLUMNS);
    localparam int LINK_W = $clog2(NUM_COLUMNS + 2);
    localparam int ROW_W  = $clog2(B_ROWS + 1);
    localparam int ENT_W  = $clog2(B_ENTRIES);
    localparam int TOP_W  = $clog2(TOP_MAX);
    localparam int SUM_W  = 48;
    localparam int CNT_W  = 11;

    localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(NUM_COLUMNS);
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_COLUMNS + 1);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_ROW_START = 2'd0,
        MODE_B_ENTRY   = 2'd1,
        MODE_A_ENTRY   = 2'd2,
        MODE_ROW_DONE  = 2'd3
    } mode_t;

    localparam logic CFG_TOP_COUNT = 1'b0;
    localparam logic CFG_FLOOR     = 1'b1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [11:0]        slot;
        logic [12:0]        start_req;
        logic [9:0]         column;
        logic signed [15:0] value;
        logic               row_end;
    } in_word_t;

    typedef struct packed {
        logic [9:0]         result_column;
        logic signed [47:0] score;
        logic [5:0]         rank;
        logic               last;
        logic               none;
        logic [10:0]        above_count;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW_LO,
        ST_ROW_HI,
        ST_ENT_RD,
        ST_ENT_WAIT,
        ST_MAC,
        ST_WRITE,
        ST_FIN_RD,
        ST_FIN_WAIT,
        ST_INSERT,
        ST_EMIT_RD,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    // Sequencer request to the multiply-accumulate unit.
    typedef struct packed {
        logic               mac_go;
        logic signed [15:0] a_val;
        logic signed [15:0] b_val;
        logic signed [47:0] sum_in;
    } acc_req_t;

    function automatic logic better(input logic signed [47:0] s1, input logic [COL_W-1:0] c1,
                                    input logic signed [47:0] s2, input logic [COL_W-1:0] c2);
        return (s1 > s2) || ((s1 == s2) && (c1 < c2));
    endfunction

endpackage

@@ hw/rtl/srp_mac.sv @@
// ----------------------------------------------------------------------------
// srp_mac
// Multiply-accumulate unit: registered product, then saturating add.
// ----------------------------------------------------------------------------
module srp_mac
(
    input  logic                     clk,
    input  srp_pkg::acc_req_t        req,
    output logic signed [47:0]       sum_out
);

    logic signed [31:0] prod_reg;
    logic signed [47:0] sum_in_reg;
    logic signed [48:0] wide;
    logic signed [47:0] sum_next;

    always_ff @(posedge clk)
    begin
        if (req.mac_go)
        begin
            prod_reg   <= req.a_val * req.b_val;
            sum_in_reg <= req.sum_in;
        end
    end

    always_comb
    begin
        wide = {sum_in_reg[47], sum_in_reg} + 49'(prod_reg);
        if (wide > 49'sh0_7FFF_FFFF_FFFF)
            sum_next = srp_pkg::SUM_MAX;
        else if (wide < -49'sh0_8000_0000_0000)
            sum_next = srp_pkg::SUM_MIN;
        else
            sum_next = wide[47:0];
    end

    assign sum_out = sum_next;

endmodule

@@ hw/rtl/sparse_row_product_top_n.sv @@
// ----------------------------------------------------------------------------
// sparse_row_product_top_n
// Sparse row product with top-N selection per row.
//
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall, word in_data
//  out     | output    | out_valid / out_stall, word out_data
//  cfg     | input     | cfg_we, cfg_index, cfg_data
//
// A B write is stored on acceptance. An A entry reads its B row bounds, then
// per B entry reads the entry and its column sum, multiplies, adds and writes
// the sum back. Ending a row walks the touched columns, inserts each kept
// candidate into the best list, shifting lower ones down, then reads and emits
// each result. After reset a clearing pass marks every column unlinked. The
// input is stalled then and while a word is in work; output holds.
// ----------------------------------------------------------------------------
module sparse_row_product_top_n
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  srp_pkg::in_word_t     in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output srp_pkg::out_word_t    out_data,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [47:0]           cfg_data
);

`include "sparse_row_product_top_n_defines.svh"

    localparam int CW     = srp_pkg::COL_W;
    localparam int LW     = srp_pkg::LINK_W;
    localparam int EW     = srp_pkg::ENT_W;
    localparam int TW     = srp_pkg::TOP_W;
    localparam int ROW_WX = srp_pkg::ROW_W;

    // Memories.
    logic [12:0]        row_start_mem [srp_pkg::B_ROWS+1];
    logic [CW-1:0]      ent_col_mem   [srp_pkg::B_ENTRIES];
    logic signed [15:0] ent_val_mem   [srp_pkg::B_ENTRIES];
    logic signed [47:0] sum_mem       [srp_pkg::NUM_COLUMNS];
    logic [LW-1:0]      link_mem      [srp_pkg::NUM_COLUMNS];
    logic signed [47:0] best_s_mem    [srp_pkg::TOP_MAX];
    logic [CW-1:0]      best_c_mem    [srp_pkg::TOP_MAX];

    srp_pkg::state_t state_reg, state_next;

    logic [6:0]         top_count_reg;
    logic signed [47:0] floor_reg;
    logic [LW-1:0]      head_reg;
    logic [10:0]        touched_reg;
    logic [CW-1:0]      clr_reg;

    logic signed [15:0] a_val_reg;
    logic               end_pending_reg;
    logic [ROW_WX-1:0]  brow_reg;
    logic [13:0]        lo_reg;
    logic [13:0]        hi_lim;
    logic [12:0]        row_rd_reg;
    logic [CW-1:0]      ecol_reg;
    logic signed [15:0] eval_reg;
    logic signed [47:0] sum_rd_reg;
    logic               linked_rd;
    logic [LW-1:0]      link_rd_reg;
    logic [10:0]        n_reg;
    logic [CW-1:0]      cur_c_reg;
    logic signed [47:0] cur_s_reg;
    logic [6:0]         kept_reg;
    logic [10:0]        above_reg;
    logic [6:0]         p_reg;
    logic [6:0]         limit;
    logic signed [47:0] bs_rd_reg;
    logic [CW-1:0]      bc_rd_reg;
    logic [6:0]         emit_i_reg;

    srp_pkg::acc_req_t  req;
    logic signed [47:0] mac_sum;

    logic accept;
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != srp_pkg::ST_IDLE);

    // End of the B row: the next row start clamped to the entry count.
    assign hi_lim = (row_rd_reg > 13'(srp_pkg::B_ENTRIES)) ? 14'(srp_pkg::B_ENTRIES) :
                    14'(row_rd_reg);

    assign linked_rd = (link_rd_reg != srp_pkg::LINK_NONE);

    always_comb
    begin
        limit = top_count_reg;
        if (limit == 7'd0)
            limit = 7'd1;
        if (limit > 7'(srp_pkg::TOP_MAX))
            limit = 7'(srp_pkg::TOP_MAX);
    end

    srp_mac u_mac (.clk(clk), .req(req), .sum_out(mac_sum));

    always_comb
    begin
        req.mac_go = (state_reg == srp_pkg::ST_MAC);
        req.a_val  = a_val_reg;
        req.b_val  = eval_reg;
        req.sum_in = linked_rd ? sum_rd_reg : 48'sd0;
    end

    // Insertion compare against the entry below position p.
    logic ins_better, cand, has_room;
    assign ins_better = srp_pkg::better(cur_s_reg, cur_c_reg, bs_rd_reg, bc_rd_reg);
    assign cand       = cur_s_reg > floor_reg;
    assign has_room   = kept_reg < limit;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srp_pkg::ST_CLEAR:
            begin
                if (clr_reg == CW'(srp_pkg::NUM_COLUMNS - 1))
                    state_next = srp_pkg::ST_IDLE;
            end
            srp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (srp_pkg::mode_t'(in_data.mode))
                        srp_pkg::MODE_ROW_START, srp_pkg::MODE_B_ENTRY:
                            state_next = srp_pkg::ST_IDLE;
                        srp_pkg::MODE_A_ENTRY:
                            state_next = (32'(in_data.column) < srp_pkg::B_ROWS) ?
                                         srp_pkg::ST_ROW_LO :
                                         (in_data.row_end ? srp_pkg::ST_FIN_RD :
                                          srp_pkg::ST_IDLE);
                        default:
                            state_next = srp_pkg::ST_FIN_RD;
                    endcase
                end
            end
            srp_pkg::ST_ROW_LO:   state_next = srp_pkg::ST_ROW_HI;
            srp_pkg::ST_ROW_HI:   state_next = srp_pkg::ST_ENT_RD;
            srp_pkg::ST_ENT_RD:
            begin
                if (lo_reg >= hi_lim)
                    state_next = end_pending_reg ? srp_pkg::ST_FIN_RD : srp_pkg::ST_IDLE;
                else
                    state_next = srp_pkg::ST_ENT_WAIT;
            end
            srp_pkg::ST_ENT_WAIT:
                state_next = (32'(ecol_reg) < srp_pkg::NUM_COLUMNS) ?
                             srp_pkg::ST_MAC : srp_pkg::ST_ENT_RD;
            srp_pkg::ST_MAC:      state_next = srp_pkg::ST_WRITE;
            srp_pkg::ST_WRITE:    state_next = srp_pkg::ST_ENT_RD;
            srp_pkg::ST_FIN_RD:
            begin
                if (n_reg < touched_reg && 32'(head_reg) < srp_pkg::NUM_COLUMNS)
                    state_next = srp_pkg::ST_FIN_WAIT;
                else
                    state_next = srp_pkg::ST_EMIT_RD;
            end
            srp_pkg::ST_FIN_WAIT:
            begin
                if (cand && (has_room || kept_reg == 7'd0 || ins_better))
                    state_next = srp_pkg::ST_INSERT;
                else
                    state_next = srp_pkg::ST_FIN_RD;
            end
            srp_pkg::ST_INSERT:
            begin
                if (p_reg == 7'd0 || !ins_better)
                    state_next = srp_pkg::ST_FIN_RD;
            end
            srp_pkg::ST_EMIT_RD:  state_next = srp_pkg::ST_EMIT;
            srp_pkg::ST_EMIT:
            begin
                if (!out_stall && out_data.last)
                    state_next = srp_pkg::ST_IDLE;
                else if (!out_stall)
                    state_next = srp_pkg::ST_EMIT_RD;
            end
            default: state_next = srp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= srp_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Configuration and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_count_reg <= 7'd10;
            floor_reg     <= 48'sd0;
            head_reg      <= srp_pkg::LINK_END;
            touched_reg   <= 11'd0;
            kept_reg      <= 7'd0;
            above_reg     <= 11'd0;
            n_reg         <= 11'd0;
            emit_i_reg    <= 7'd0;
            clr_reg       <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == srp_pkg::CFG_TOP_COUNT)
                top_count_reg <= cfg_data[6:0];
            if (cfg_we && cfg_index == srp_pkg::CFG_FLOOR)
                floor_reg <= cfg_data;
            if (state_reg == srp_pkg::ST_CLEAR)
                clr_reg <= clr_reg + CW'(1);
            if (state_reg == srp_pkg::ST_WRITE && !linked_rd)
            begin
                head_reg    <= LW'(ecol_reg);
                touched_reg <= touched_reg + 11'd1;
            end
            if (state_reg == srp_pkg::ST_FIN_RD && state_next == srp_pkg::ST_FIN_WAIT)
                n_reg <= n_reg + 11'd1;
            if (state_reg == srp_pkg::ST_FIN_WAIT)
            begin
                head_reg <= link_rd_reg;
                if (cand && above_reg != 11'd2047)
                    above_reg <= above_reg + 11'd1;
                if (state_next == srp_pkg::ST_INSERT && has_room)
                    kept_reg <= kept_reg + 7'd1;
            end
            if (state_reg == srp_pkg::ST_FIN_RD && state_next == srp_pkg::ST_EMIT_RD)
            begin
                head_reg    <= srp_pkg::LINK_END;
                touched_reg <= 11'd0;
                n_reg       <= 11'd0;
                emit_i_reg  <= 7'd0;
            end
            if (state_reg == srp_pkg::ST_EMIT && !out_stall)
            begin
                emit_i_reg <= emit_i_reg + 7'd1;
                if (out_data.last)
                begin
                    kept_reg  <= 7'd0;
                    above_reg <= 11'd0;
                end
            end
        end
    end

    // Position whose lower neighbor is needed in the next insertion step.
    logic [6:0] p_next_pos;
    always_comb
    begin
        if (state_reg == srp_pkg::ST_FIN_WAIT)
            p_next_pos = has_room ? kept_reg : kept_reg - 7'd1;
        else
            p_next_pos = p_reg - 7'd1;
    end

    // Datapath registers and memories.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_val_reg       <= in_data.value;
            end_pending_reg <= in_data.row_end;
            brow_reg        <= ROW_WX'(in_data.column);
            if (in_data.mode == srp_pkg::MODE_ROW_START &&
                32'(in_data.slot) <= srp_pkg::B_ROWS)
                row_start_mem[ROW_WX'(in_data.slot)] <= in_data.start_req;
            if (in_data.mode == srp_pkg::MODE_B_ENTRY &&
                32'(in_data.slot) < srp_pkg::B_ENTRIES)
            begin
                ent_col_mem[EW'(in_data.slot)] <= in_data.column;
                ent_val_mem[EW'(in_data.slot)] <= in_data.value;
            end
        end

        if (state_reg == srp_pkg::ST_ROW_LO)
            row_rd_reg <= row_start_mem[brow_reg];
        if (state_reg == srp_pkg::ST_ROW_HI)
        begin
            row_rd_reg <= row_start_mem[ROW_WX'(brow_reg + ROW_WX'(1))];
            lo_reg     <= 14'(row_rd_reg);
        end

        if (state_reg == srp_pkg::ST_ENT_RD && lo_reg < hi_lim)
        begin
            ecol_reg <= ent_col_mem[EW'(lo_reg)];
            eval_reg <= ent_val_mem[EW'(lo_reg)];
            lo_reg   <= lo_reg + 14'd1;
        end
        if (state_reg == srp_pkg::ST_ENT_WAIT)
        begin
            sum_rd_reg  <= sum_mem[ecol_reg];
            link_rd_reg <= link_mem[ecol_reg];
        end
        if (state_reg == srp_pkg::ST_WRITE)
        begin
            sum_mem[ecol_reg] <= mac_sum;
            if (!linked_rd)
                link_mem[ecol_reg] <= head_reg;
        end
        if (state_reg == srp_pkg::ST_CLEAR)
            link_mem[clr_reg] <= srp_pkg::LINK_NONE;

        if (state_reg == srp_pkg::ST_FIN_RD && state_next == srp_pkg::ST_FIN_WAIT)
        begin
            cur_c_reg   <= head_reg[CW-1:0];
            cur_s_reg   <= sum_mem[head_reg[CW-1:0]];
            link_rd_reg <= link_mem[head_reg[CW-1:0]];
            link_mem[head_reg[CW-1:0]] <= srp_pkg::LINK_NONE;
            // Lowest kept entry, compared against when the buffer is full.
            bs_rd_reg   <= best_s_mem[TW'(kept_reg - 7'd1)];
            bc_rd_reg   <= best_c_mem[TW'(kept_reg - 7'd1)];
        end
        if (state_reg == srp_pkg::ST_FIN_WAIT || state_reg == srp_pkg::ST_INSERT)
        begin
            // Read the neighbor of the next insertion slot.
            bs_rd_reg <= best_s_mem[TW'(p_next_pos - 7'd1)];
            bc_rd_reg <= best_c_mem[TW'(p_next_pos - 7'd1)];
        end
        if (state_reg == srp_pkg::ST_INSERT)
        begin
            if (p_reg != 7'd0 && ins_better)
            begin
                best_s_mem[TW'(p_reg)] <= bs_rd_reg;
                best_c_mem[TW'(p_reg)] <= bc_rd_reg;
            end
            else
            begin
                best_s_mem[TW'(p_reg)] <= cur_s_reg;
                best_c_mem[TW'(p_reg)] <= cur_c_reg;
            end
        end
        if (state_reg == srp_pkg::ST_FIN_WAIT)
            p_reg <= has_room ? kept_reg : kept_reg - 7'd1;
        else if (state_reg == srp_pkg::ST_INSERT)
            p_reg <= p_reg - 7'd1;
        if (state_reg == srp_pkg::ST_EMIT_RD)
        begin
            bs_rd_reg <= best_s_mem[TW'(emit_i_reg)];
            bc_rd_reg <= best_c_mem[TW'(emit_i_reg)];
        end
    end

    // Output word.
    always_comb
    begin
        out_valid = (state_reg == srp_pkg::ST_EMIT);
        if (kept_reg == 7'd0)
        begin
            out_data.result_column = '0;
            out_data.score         = '0;
            out_data.rank          = '0;
            out_data.last          = 1'b1;
            out_data.none          = 1'b1;
            out_data.above_count   = '0;
        end
        else
        begin
            out_data.result_column = bc_rd_reg;
            out_data.score         = bs_rd_reg;
            out_data.rank          = emit_i_reg[5:0];
            out_data.last          = (emit_i_reg + 7'd1 == kept_reg);
            out_data.none          = 1'b0;
            out_data.above_count   = above_reg;
        end
    end

    `SRP_ASSERT(a_no_accept_busy, clk, rst_n, (state_reg != srp_pkg::ST_IDLE) |-> in_stall,
                "input accepted while busy")
    `SRP_ASSERT(a_kept_limit, clk, rst_n, (kept_reg <= 7'(srp_pkg::TOP_MAX)),
                "kept count above buffer depth")
    `SRP_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid,
                "result word dropped while stalled")

endmodule

@@ verif/srp_checker.sv @@
// ----------------------------------------------------------------------------
// srp_checker
// Watches the word, result and register ports of the sparse row product
// block. It keeps its own copy of the B matrix, the column sums and the
// touched-column list, predicts the ranked results of every finished row
// and compares them field by field with the words that leave the block.
// ----------------------------------------------------------------------------
module srp_checker
    import srp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  in_word_t   in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  out_word_t  out_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [47:0] cfg_data,
    output int         fail_count,
    output int         waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI = longint'(SUM_MAX);
    localparam longint SAT_LO = -SAT_HI - 1;

    int     row_start [0:B_ROWS];
    int     ent_col   [0:B_ENTRIES-1];
    longint ent_val   [0:B_ENTRIES-1];
    longint col_sum   [0:NUM_COLUMNS-1];
    int     col_link  [0:NUM_COLUMNS-1];
    int     head;
    int     touched;
    int     keep_max;
    longint floor_val;

    out_word_t ranked_q[$];

    assign waiting = ranked_q.size();

    initial
    begin
        fail_count = 0;
        keep_max   = 10;
        floor_val  = 0;
        head       = int'(LINK_END);
        touched    = 0;
        for (int c = 0; c < NUM_COLUMNS; c++)
        begin
            col_sum[c]  = 0;
            col_link[c] = int'(LINK_NONE);
        end
    end

    function automatic bit ranks_higher(longint s1, int c1, longint s2, int c2);
        return (s1 > s2) || ((s1 == s2) && (c1 < c2));
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic add_row(input int brow, input longint a);
        int     lo;
        int     hi;
        int     c;
        longint s;
        lo = row_start[brow];
        hi = row_start[brow + 1];
        if (hi > B_ENTRIES)
            hi = B_ENTRIES;
        for (int k = lo; k < hi; k++)
        begin
            c = ent_col[k];
            s = col_sum[c] + a * ent_val[k];
            if (s > SAT_HI)
                s = SAT_HI;
            if (s < SAT_LO)
                s = SAT_LO;
            col_sum[c] = s;
            if (col_link[c] == int'(LINK_NONE))
            begin
                col_link[c] = head;
                head = c;
                touched++;
            end
        end
    endtask

    task automatic close_row();
        longint    best_s [TOP_MAX];
        int        best_c [TOP_MAX];
        int        lim;
        int        kept;
        int        above;
        int        c;
        int        p;
        longint    s;
        out_word_t w;
        lim   = (keep_max == 0) ? 1 : ((keep_max > TOP_MAX) ? TOP_MAX : keep_max);
        kept  = 0;
        above = 0;
        for (int n = 0; n < touched && head < NUM_COLUMNS; n++)
        begin
            c = head;
            s = col_sum[c];
            if (s > floor_val)
            begin
                if (above < 2047)
                    above++;
                if (kept < lim || ranks_higher(s, c, best_s[kept-1], best_c[kept-1]))
                begin
                    p = (kept < lim) ? kept : kept - 1;
                    while (p > 0 && ranks_higher(s, c, best_s[p-1], best_c[p-1]))
                    begin
                        best_s[p] = best_s[p-1];
                        best_c[p] = best_c[p-1];
                        p--;
                    end
                    best_s[p] = s;
                    best_c[p] = c;
                    if (kept < lim)
                        kept++;
                end
            end
            head = col_link[c];
            col_link[c] = int'(LINK_NONE);
            col_sum[c] = 0;
        end
        head    = int'(LINK_END);
        touched = 0;
        if (kept == 0)
        begin
            w = '0;
            w.last = 1'b1;
            w.none = 1'b1;
            ranked_q = {ranked_q, w};
        end
        for (int i = 0; i < kept; i++)
        begin
            w.result_column = best_c[i][9:0];
            w.score         = best_s[i][47:0];
            w.rank          = i[5:0];
            w.last          = (i + 1 == kept);
            w.none          = 1'b0;
            w.above_count   = above[10:0];
            ranked_q = {ranked_q, w};
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TOP_COUNT)
                    keep_max = int'(cfg_data[6:0]);
                else
                    floor_val = longint'($signed(cfg_data));
            end
            if (in_valid && !in_stall)
            begin
                case (mode_t'(in_data.mode))
                    MODE_ROW_START:
                        if (in_data.slot <= B_ROWS)
                            row_start[in_data.slot] = int'(in_data.start_req);
                    MODE_B_ENTRY:
                    begin
                        ent_col[in_data.slot] = int'(in_data.column);
                        ent_val[in_data.slot] = longint'(in_data.value);
                    end
                    MODE_A_ENTRY:
                    begin
                        add_row(int'(in_data.column), longint'(in_data.value));
                        if (in_data.row_end)
                            close_row();
                    end
                    default:
                        close_row();
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (ranked_q.size() == 0)
                    report("unexpected result word", longint'(out_data.result_column), -1);
                else
                begin
                    out_word_t e;
                    e = ranked_q.pop_front();
                    if (out_data.result_column !== e.result_column)
                        report("result_column", out_data.result_column, e.result_column);
                    if (out_data.score !== e.score)
                        report("score", longint'(out_data.score), longint'(e.score));
                    if (out_data.rank !== e.rank)
                        report("rank", out_data.rank, e.rank);
                    if (out_data.last !== e.last)
                        report("last", out_data.last, e.last);
                    if (out_data.none !== e.none)
                        report("none", out_data.none, e.none);
                    if (out_data.above_count !== e.above_count)
                        report("above_count", out_data.above_count, e.above_count);
                end
            end
        end
    end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the sparse row product block. Loads a small B matrix with
// directed corner rows, then runs A rows through several top-count and
// floor settings with random idle gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import srp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [47:0] cfg_data;
    logic        in_acc;
    int          fail_count;
    int          waiting;
    bit          calm;

    // Shadow of what has been written, so that no A entry reads unwritten B.
    bit rs_ok  [0:B_ROWS];
    int rs_val [0:B_ROWS];
    bit ent_ok [0:B_ENTRIES-1];
    int fill_pos;

    sparse_row_product_top_n i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    srp_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        in_acc <= in_valid && !in_stall;

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = !calm && ($urandom_range(0, 99) < 34);
        end
    end

    initial
    begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit row_ready(int r);
        int hi;
        if (!rs_ok[r] || !rs_ok[r+1])
            return 0;
        hi = (rs_val[r+1] > B_ENTRIES) ? B_ENTRIES : rs_val[r+1];
        for (int k = rs_val[r]; k < hi; k++)
            if (!ent_ok[k])
                return 0;
        return 1;
    endfunction

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_word_t rand_fill();
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        return rnd[$bits(in_word_t)-1:0];
    endfunction

    task automatic push_word(input in_word_t w);
        if (!calm && $urandom_range(0, 99) < 34)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = w;
        do
            @(negedge clk);
        while (!in_acc);
        in_valid = 1'b0;
        if (mode_t'(w.mode) == MODE_ROW_START && w.slot <= B_ROWS)
        begin
            rs_ok[w.slot]  = 1'b1;
            rs_val[w.slot] = int'(w.start_req);
        end
        else if (mode_t'(w.mode) == MODE_B_ENTRY)
            ent_ok[w.slot] = 1'b1;
    endtask

    // Unused fields carry random bits so that the block is seen to ignore them.
    task automatic row_start_word(input int r, input int s);
        in_word_t w;
        w = rand_fill();
        w.mode      = MODE_ROW_START;
        w.slot      = r[11:0];
        w.start_req = s[12:0];
        push_word(w);
    endtask

    task automatic entry_word(input int k, input int c, input logic signed [15:0] v);
        in_word_t w;
        w = rand_fill();
        w.mode   = MODE_B_ENTRY;
        w.slot   = k[11:0];
        w.column = c[9:0];
        w.value  = v;
        push_word(w);
    endtask

    task automatic a_word(input int r, input logic signed [15:0] v, input bit fin);
        in_word_t w;
        w = rand_fill();
        w.mode    = MODE_A_ENTRY;
        w.column  = r[9:0];
        w.value   = v;
        w.row_end = fin;
        push_word(w);
    endtask

    task automatic row_done_word();
        in_word_t w;
        w = rand_fill();
        w.mode = MODE_ROW_DONE;
        push_word(w);
    endtask

    task automatic set_regs(input int top_n, input longint floor_v);
        while (waiting != 0)
            @(negedge clk);
        // The block is idle once its input is no longer stalled.
        while (in_stall)
            @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = CFG_TOP_COUNT;
        cfg_data  = 48'(top_n);
        @(negedge clk);
        cfg_index = CFG_FLOOR;
        cfg_data  = floor_v[47:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_word();
        int  r;
        int  pick;
        r = $urandom_range(0, 99);
        if (r < 8)
            entry_word(($urandom_range(0, 9) < 7) ? $urandom_range(0, fill_pos - 1)
                                                  : $urandom_range(0, B_ENTRIES - 1),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, 47),
                       pick_value());
        else if (r < 11)
        begin
            if ($urandom_range(0, 1) == 0)
                row_start_word($urandom_range(B_ROWS + 1, 4095), $urandom_range(0, 8191));
            else
                row_start_word($urandom_range(2, 39), $urandom_range(0, fill_pos));
        end
        else if (r < 16)
            row_done_word();
        else
        begin
            pick = 0;
            for (int t = 0; t < 30; t++)
            begin
                r = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 41)
                                               : $urandom_range(0, B_ROWS - 1);
                if (row_ready(r))
                begin
                    pick = r;
                    break;
                end
            end
            a_word(pick, pick_value(), $urandom_range(0, 99) < 30);
        end
    endtask

    initial
    begin
        int     top_set [6];
        longint floor_set [6];
        top_set   = '{10, 0, 64, 127, 1, 3};
        floor_set = '{0, -(64'sd1 <<< 40), longint'(SUM_MIN), 0,
                      longint'(SUM_MAX), 64'sd1 <<< 20};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_TOP_COUNT;
        cfg_data  = '0;
        calm      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Row 0 adds into a repeated column and hits the value extremes;
        // row 1 gives two columns the same sum to check the tie order.
        row_start_word(0, 0);
        entry_word(0, 5, 16'sh0800);
        entry_word(1, 9, 16'sh0800);
        entry_word(2, 5, 16'sh8000);
        entry_word(3, 1023, 16'sh7fff);
        row_start_word(1, 4);
        entry_word(4, 3, 16'sd100);
        entry_word(5, 1, 16'sd100);
        fill_pos = 6;
        for (int r = 2; r <= 40; r++)
        begin
            row_start_word(r, fill_pos);
            if (r < 40)
                repeat ($urandom_range(0, 7))
                begin
                    entry_word(fill_pos, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                                     : $urandom_range(0, 47),
                               pick_value());
                    fill_pos++;
                end
        end
        // Row 40 ends below its start, so it is empty.
        row_start_word(41, 1);
        // The last row runs up to the end of the entry store.
        row_start_word(B_ROWS - 1, B_ENTRIES - 6);
        row_start_word(B_ROWS, B_ENTRIES);
        for (int k = B_ENTRIES - 6; k < B_ENTRIES; k++)
            entry_word(k, $urandom_range(0, 1023), pick_value());
        row_start_word(4095, 8191);

        set_regs(top_set[0], floor_set[0]);
        a_word(0, 16'sh7fff, 1'b0);
        a_word(0, 16'sh8000, 1'b1);
        a_word(1, 16'sh0800, 1'b1);
        row_done_word();
        a_word(40, 16'sh0100, 1'b1);
        a_word(B_ROWS - 1, 16'sh8000, 1'b0);
        a_word(0, 16'sh0001, 1'b0);
        row_done_word();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
                set_regs(top_set[ph], floor_set[ph]);
            for (int n = 0; n < 44; n++)
            begin
                calm = (ph == 2) && (n >= 10) && (n < 40);
                random_word();
            end
            calm = 1'b0;
            row_done_word();
        end

        while (waiting != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/srp_pkg.sv
hw/rtl/srp_mac.sv
hw/rtl/sparse_row_product_top_n.sv
verif/srp_checker.sv
verif/tb_top.sv
